@@ rtl/mlcw_pkg.sv @@
// shared types, constants and register codes for the light curtain width core
// no dependencies; imported by every module of the block
`default_nettype none

package mlcw_pkg;

  // design defaults, handed to the top-level parameters
  localparam int NUM_ELEMENTS_DEF = 80;
  localparam int MUX_WAYS_DEF     = 8;

  // fixed field widths
  localparam int SENSOR_LINES = 10;
  localparam int DIAM_W       = 12;
  localparam int MUX_SEL_W    = 3;
  localparam int WIDTH_OUT_W  = 10;
  localparam int WIDTH_W      = 16;
  localparam int COUNT_W      = 7;
  localparam int THRESH_W     = 7;
  localparam int DIV_W        = 3;
  localparam int SWEEP_W      = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [WIDTH_W-1:0] WIDTH_OUT_MAX = WIDTH_W'(1023);

  // width arithmetic: w = n*10, corrected w*(3900-d)/4000 = ((w*(3900-d))>>5)/125
  localparam int MM_PER_ELEMENT = 10;
  localparam logic [DIAM_W-1:0] CORR_BASE = DIAM_W'(3900);
  localparam int CORR_SHIFT = 5;
  localparam int CORR_DIV   = 125;
  localparam int RECIP_K    = 26;
  localparam int RECIP_W    = 20;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((2 ** RECIP_K) / CORR_DIV);

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_DIVISOR      = 4'd0,
    REG_SWEEPS_LIMIT      = 4'd1,
    REG_COUNT_THRESHOLD   = 4'd2,
    REG_CORRECTION_ENABLE = 4'd3
  } cfg_reg_e;

  localparam logic [DIV_W-1:0]    TICK_DIVISOR_RST    = DIV_W'(5);
  localparam logic [SWEEP_W-1:0]  SWEEPS_LIMIT_RST    = SWEEP_W'(100);
  localparam logic [THRESH_W-1:0] COUNT_THRESHOLD_RST = THRESH_W'(50);

  typedef struct packed {
    logic [SENSOR_LINES-1:0] sensor_bits;
    logic [DIAM_W-1:0]       diameter_mm;
  } in_item_t;

  typedef struct packed {
    logic [MUX_SEL_W-1:0]   mux_select;
    logic                   width_report;
    logic [WIDTH_OUT_W-1:0] width_mm;
    logic                   width_ok;
  } out_item_t;

  // control broadcast to the counter cells
  typedef struct packed {
    logic sample;
    logic shift;
  } cell_ctrl_t;

  // control for the scan accumulator
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/mlcw_cell.sv @@
// one element counter of the counter chain
// depends on mlcw_pkg
`default_nettype none

module mlcw_cell
  import mlcw_pkg::*;
#(
  parameter int MUX_W   = 3,
  parameter int WAY_IDX = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic [MUX_W-1:0]   mux_i,
  input  wire logic               line_bit_i,
  input  wire logic [COUNT_W-1:0] nbr_i,
  output logic      [COUNT_W-1:0] count_o
);

  logic [COUNT_W-1:0] count_q;
  logic               hit;

  assign hit = (mux_i == MUX_W'(WAY_IDX)) && line_bit_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.shift) begin
      // scan: take the upper neighbor, zero enters at the top
      count_q <= nbr_i;
    end else if (ctrl_i.sample && hit && (count_q != COUNT_MAX)) begin
      count_q <= count_q + COUNT_W'(1);
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

@@ rtl/mlcw_scan.sv @@
// scan accumulator: counts shadowed elements, fills single gaps, counts rising edges
// depends on mlcw_pkg
`default_nettype none

module mlcw_scan
  import mlcw_pkg::*;
#(
  parameter int CNT_W = 7
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire scan_ctrl_t          ctrl_i,
  input  wire logic [COUNT_W-1:0]  value_i,
  input  wire logic [THRESH_W-1:0] threshold_i,
  output logic      [CNT_W-1:0]    total_o,
  output logic                     multi_edge_o
);

  logic [CNT_W-1:0] total_q;
  logic [1:0]       rises_q;
  logic             prev_q;
  logic             prev2_q;
  logic             shadow;
  logic             gap;

  assign shadow = value_i > COUNT_W'(threshold_i);
  // lone clear element between two shadowed ones
  assign gap    = shadow && !prev_q && prev2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      rises_q <= '0;
      prev_q  <= 1'b0;
      prev2_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      total_q <= '0;
      rises_q <= '0;
      prev_q  <= 1'b0;
      prev2_q <= 1'b0;
    end else if (ctrl_i.step) begin
      if (shadow) begin
        total_q <= total_q + (gap ? CNT_W'(2) : CNT_W'(1));
        if (!prev_q && !prev2_q && (rises_q != 2'd2)) begin
          rises_q <= rises_q + 2'd1;
        end
        prev2_q <= gap ? 1'b1 : prev_q;
        prev_q  <= 1'b1;
      end else begin
        prev2_q <= prev_q;
        prev_q  <= 1'b0;
      end
    end
  end

  assign total_o      = total_q;
  assign multi_edge_o = (rises_q == 2'd2);

endmodule

`default_nettype wire

@@ rtl/mlcw_width.sv @@
// width pipeline: n*10 and optional parallax correction, four register stages
// depends on mlcw_pkg
`default_nettype none

module mlcw_width
  import mlcw_pkg::*;
#(
  parameter int CNT_W = 7
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [CNT_W-1:0]   total_i,
  input  wire logic [DIAM_W-1:0]  diameter_i,
  input  wire logic               corr_en_i,
  output logic                    done_o,
  output logic      [WIDTH_W-1:0] width_o
);

  localparam int W0_W = CNT_W + 4;
  localparam int P_W  = W0_W + DIAM_W;
  localparam int Y_W  = P_W - CORR_SHIFT;
  localparam int YM_W = Y_W + RECIP_W;
  localparam int Q_W  = YM_W - RECIP_K;

  logic [2:0]         v_q;
  logic               done_q;
  logic [W0_W-1:0]    w0_q;
  logic [DIAM_W-1:0]  diff_q;
  logic [2:0]         corr_q;
  logic [W0_W-1:0]    w1_q;
  logic [W0_W-1:0]    w2_q;
  logic [Y_W-1:0]     y1_q;
  logic [Y_W-1:0]     y2_q;
  logic [YM_W-1:0]    ym_q;
  logic [WIDTH_W-1:0] res_q;

  logic [P_W-1:0]     prod;
  logic [Q_W-1:0]     q_est;
  logic [Y_W-1:0]     rem;
  logic [Q_W-1:0]     q_fix;

  assign prod  = P_W'(w0_q) * P_W'(diff_q);
  assign q_est = ym_q[YM_W-1:RECIP_K];
  assign rem   = y2_q - Y_W'(Y_W'(q_est) * Y_W'(CORR_DIV));
  // reciprocal estimate is low by at most one
  assign q_fix = (rem >= Y_W'(CORR_DIV)) ? q_est + Q_W'(1) : q_est;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v_q    <= {v_q[1:0], start_i};
      done_q <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 0: raw width and distance term
    w0_q      <= W0_W'(total_i) * W0_W'(MM_PER_ELEMENT);
    diff_q    <= (diameter_i >= CORR_BASE) ? '0 : CORR_BASE - diameter_i;
    corr_q[0] <= corr_en_i;
    // stage 1: scaled product
    y1_q      <= prod[P_W-1:CORR_SHIFT];
    w1_q      <= w0_q;
    corr_q[1] <= corr_q[0];
    // stage 2: reciprocal multiply
    ym_q      <= YM_W'(y1_q) * YM_W'(RECIP_M);
    y2_q      <= y1_q;
    w2_q      <= w1_q;
    corr_q[2] <= corr_q[1];
    // stage 3: quotient correction
    res_q     <= corr_q[2] ? WIDTH_W'(q_fix) : WIDTH_W'(w2_q);
  end

  assign done_o  = done_q;
  assign width_o = res_q;

endmodule

`default_nettype wire

@@ rtl/multiplexed_light_curtain_width_core.sv @@
// top level of the multiplexed light curtain width meter
// depends on mlcw_pkg, mlcw_cell, mlcw_scan, mlcw_width
//
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+---------------------------
// input    | in        | in_valid_i/in_ready_o  | in_item_i   (in_item_t)
// result   | out       | out_valid_o/out_ready_i| out_item_o  (out_item_t)
// config   | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// one result per input transfer; the result of a tick that does not close the
// last sweep is registered and sits in the output register while the next
// tick is taken. a tick that closes the last sweep shifts the whole counter
// chain out through the scan accumulator, then runs the four-stage width
// pipeline, and only then is the next transfer taken. the scan itself clears
// the counters. reset restores register defaults and zeroes all counters at
// once. a stalled result holds off further input.
`default_nettype none

module multiplexed_light_curtain_width_core
  import mlcw_pkg::*;
#(
  parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF,
  parameter int MUX_WAYS     = MUX_WAYS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int MUX_W = $clog2(MUX_WAYS);
  localparam int IDX_W = $clog2(NUM_ELEMENTS);
  localparam int CNT_W = $clog2(NUM_ELEMENTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAUNCH,
    ST_WAIT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [DIV_W-1:0]    tick_divisor_q;
  logic [SWEEP_W-1:0]  sweeps_limit_q;
  logic [THRESH_W-1:0] count_threshold_q;
  logic                correction_enable_q;

  // sampling state
  logic [MUX_W-1:0]    mux_q;
  logic [SWEEP_W-1:0]  sweep_q;
  logic [DIV_W-1:0]    prescale_q;
  logic [WIDTH_W-1:0]  last_width_q;
  logic [IDX_W-1:0]    scan_idx_q;
  logic [DIAM_W-1:0]   diameter_q;

  // output register
  logic                out_valid_q;
  out_item_t           out_item_q;

  logic                in_fire;
  logic                sample;
  logic                mux_last;
  logic [MUX_W-1:0]    mux_nxt;
  logic                trigger;
  cell_ctrl_t          cell_ctrl;
  scan_ctrl_t          scan_ctrl;
  logic [CNT_W-1:0]    scan_total;
  logic                scan_multi;
  logic                w_done;
  logic [WIDTH_W-1:0]  w_value;

  logic [COUNT_W-1:0]  cnt [NUM_ELEMENTS];

  // take a tick only when idle and the output register is empty or frees up this cycle
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign sample   = in_fire && (prescale_q == '0);
  assign mux_last = (mux_q == MUX_W'(MUX_WAYS - 1));
  assign mux_nxt  = mux_last ? '0 : mux_q + MUX_W'(1);
  // last sweep done: scan after this sample lands in the counters
  assign trigger  = sample && mux_last && !(sweep_q < sweeps_limit_q);

  assign cell_ctrl.sample = sample;
  assign cell_ctrl.shift  = (state_q == ST_SCAN);
  assign scan_ctrl.clear  = trigger;
  assign scan_ctrl.step   = (state_q == ST_SCAN);

  // counter chain, element i sits at line i/MUX_WAYS, mux way i%MUX_WAYS
  for (genvar i = 0; i < NUM_ELEMENTS; i++) begin : g_cell
    logic                line_bit;
    logic [COUNT_W-1:0]  nbr;

    if ((i / MUX_WAYS) < SENSOR_LINES) begin : g_line
      assign line_bit = in_item_i.sensor_bits[i / MUX_WAYS];
    end else begin : g_noline
      assign line_bit = 1'b0;
    end

    if (i == NUM_ELEMENTS - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cnt[i + 1];
    end

    mlcw_cell #(
      .MUX_W   (MUX_W),
      .WAY_IDX (i % MUX_WAYS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .mux_i      (mux_q),
      .line_bit_i (line_bit),
      .nbr_i      (nbr),
      .count_o    (cnt[i])
    );
  end

  // element zero leaves the chain first, so the scan runs in index order
  mlcw_scan #(
    .CNT_W (CNT_W)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (scan_ctrl),
    .value_i      (cnt[0]),
    .threshold_i  (count_threshold_q),
    .total_o      (scan_total),
    .multi_edge_o (scan_multi)
  );

  mlcw_width #(
    .CNT_W (CNT_W)
  ) u_width (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_LAUNCH),
    .total_i    (scan_total),
    .diameter_i (diameter_q),
    .corr_en_i  (correction_enable_q),
    .done_o     (w_done),
    .width_o    (w_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= ST_IDLE;
      tick_divisor_q      <= TICK_DIVISOR_RST;
      sweeps_limit_q      <= SWEEPS_LIMIT_RST;
      count_threshold_q   <= COUNT_THRESHOLD_RST;
      correction_enable_q <= 1'b1;
      mux_q               <= '0;
      sweep_q             <= '0;
      prescale_q          <= TICK_DIVISOR_RST;
      last_width_q        <= '0;
      scan_idx_q          <= '0;
      diameter_q          <= '0;
      out_valid_q         <= 1'b0;
      out_item_q          <= '0;
    end else begin
      // register writes
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_TICK_DIVISOR:      tick_divisor_q      <= cfg_data_i[DIV_W-1:0];
          REG_SWEEPS_LIMIT:      sweeps_limit_q      <= cfg_data_i[SWEEP_W-1:0];
          REG_COUNT_THRESHOLD:   count_threshold_q   <= cfg_data_i[THRESH_W-1:0];
          REG_CORRECTION_ENABLE: correction_enable_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      // result transfer frees the output register
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (sample) begin
              prescale_q <= tick_divisor_q;
              mux_q      <= mux_nxt;
              if (mux_last && (sweep_q < sweeps_limit_q)) begin
                sweep_q <= sweep_q + SWEEP_W'(1);
              end else if (mux_last) begin
                sweep_q <= '0;
              end
            end else begin
              prescale_q <= prescale_q - DIV_W'(1);
            end

            out_item_q.mux_select   <= MUX_SEL_W'(sample ? mux_nxt : mux_q);
            out_item_q.width_report <= 1'b0;
            out_item_q.width_mm     <= '0;
            out_item_q.width_ok     <= 1'b0;

            if (trigger) begin
              // result waits for the scan and the width pipeline
              state_q    <= ST_SCAN;
              scan_idx_q <= '0;
              diameter_q <= in_item_i.diameter_mm;
            end else begin
              out_valid_q <= 1'b1;
            end
          end
        end

        ST_SCAN: begin
          scan_idx_q <= scan_idx_q + IDX_W'(1);
          if (scan_idx_q == IDX_W'(NUM_ELEMENTS - 1)) begin
            state_q <= ST_LAUNCH;
          end
        end

        ST_LAUNCH: begin
          state_q <= ST_WAIT;
        end

        ST_WAIT: begin
          if (w_done) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            // report only a width that changed since the last report
            if (w_value != last_width_q) begin
              last_width_q            <= w_value;
              out_item_q.width_report <= 1'b1;
              out_item_q.width_mm     <= (w_value > WIDTH_OUT_MAX) ?
                                         WIDTH_OUT_MAX[WIDTH_OUT_W-1:0] :
                                         w_value[WIDTH_OUT_W-1:0];
              out_item_q.width_ok     <= !scan_multi;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // no report means zero width and a clear valid flag
  a_quiet_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.width_report) |->
      ((out_item_o.width_mm == '0) && !out_item_o.width_ok))
    else $error("result without report carries width data");

  // width pipeline finishes only while the block waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_done |-> (state_q == ST_WAIT))
    else $error("width pipeline done outside of wait");

  // a full scan leaves the chain cleared, checked at both ends of the chain
  a_chain_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LAUNCH) |-> (cnt[0] == '0) && (cnt[NUM_ELEMENTS-1] == '0))
    else $error("counter chain not cleared after scan");

  // multiplexer address stays within the sweep
  a_mux_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(mux_q) < MUX_WAYS)
    else $error("mux address out of range");

  // a scan starts from element zero of the chain
  a_scan_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && $past(state_q == ST_IDLE)) |-> (scan_idx_q == '0))
    else $error("scan started with a stale element index");

endmodule

`default_nettype wire

@@ verif/multiplexed_light_curtain_width_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for multiplexed_light_curtain_width_core
// depends on mlcw_pkg and the core rtl; results are predicted by a model kept in this file

module multiplexed_light_curtain_width_core_tb;
  import mlcw_pkg::*;

  localparam int NUM_EL        = NUM_ELEMENTS_DEF;
  localparam int WAYS          = MUX_WAYS_DEF;
  localparam int CORR_DEN      = 4000;
  // scan of the whole counter chain plus the width pipeline, with margin
  localparam int SETTLE_CYCLES = NUM_EL + 16;
  // cycles without any transfer before the run is declared hung
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_TICKS  = 1840;

  // register indexes past the end of the map, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(REG_CORRECTION_ENABLE) + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  multiplexed_light_curtain_width_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // curtain model: per-element shadow counters, mux, sweep and prescale state
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]   shadow_cnt [NUM_EL];
  logic [MUX_SEL_W-1:0] mux_q;
  logic [SWEEP_W-1:0]   sweep_q;
  logic [DIV_W-1:0]     presc_q;
  logic [WIDTH_W-1:0]   last_width_q;

  // model copy of the register file
  logic [DIV_W-1:0]     div_cfg;
  logic [SWEEP_W-1:0]   sweeps_cfg;
  logic [THRESH_W-1:0]  thr_cfg;
  logic                 corr_cfg;

  in_item_t  tick_q  [$];  // ticks waiting for the driver
  out_item_t width_q [$];  // predicted results, oldest first

  int errors = 0;

  task automatic reset_curtain();
    int i;
    for (i = 0; i < NUM_EL; i++) shadow_cnt[i] = '0;
    mux_q        = '0;
    sweep_q      = '0;
    presc_q      = TICK_DIVISOR_RST;
    last_width_q = '0;
    div_cfg      = TICK_DIVISOR_RST;
    sweeps_cfg   = SWEEPS_LIMIT_RST;
    thr_cfg      = COUNT_THRESHOLD_RST;
    corr_cfg     = 1'b1;
  endtask

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_TICK_DIVISOR:      div_cfg    = d[DIV_W-1:0];
      REG_SWEEPS_LIMIT:      sweeps_cfg = d[SWEEP_W-1:0];
      REG_COUNT_THRESHOLD:   thr_cfg    = d[THRESH_W-1:0];
      REG_CORRECTION_ENABLE: corr_cfg   = d[0];
      default: ;
    endcase
  endfunction

  // one tick: maybe sample, maybe close the last sweep and scan the counters
  function automatic out_item_t tick_curtain(in_item_t it);
    out_item_t res;
    int        k, i, idx, lit, rises, w;
    logic      prev, prev2;
    res = '0;
    if (presc_q == '0) begin
      for (k = 0; k < SENSOR_LINES; k++) begin
        idx = k * WAYS + int'(mux_q);
        if (idx < NUM_EL && it.sensor_bits[k] && shadow_cnt[idx] != COUNT_MAX)
          shadow_cnt[idx] = shadow_cnt[idx] + 1'b1;
      end
      if (int'(mux_q) + 1 < WAYS) begin
        mux_q = mux_q + 1'b1;
      end else begin
        mux_q = '0;
        if (sweep_q < sweeps_cfg) begin
          sweep_q = sweep_q + 1'b1;
        end else begin
          sweep_q = '0;
          lit     = 0;
          rises   = 0;
          prev    = 1'b0;
          prev2   = 1'b0;
          for (i = 0; i < NUM_EL; i++) begin
            if (shadow_cnt[i] > thr_cfg) begin
              lit++;
              if (!prev) rises++;
              // lone dark element between two shadowed ones: fill it, no new edge
              if (!prev && prev2) begin
                rises--;
                lit++;
                prev = 1'b1;
              end
              prev2 = prev;
              prev  = 1'b1;
            end else begin
              prev2 = prev;
              prev  = 1'b0;
            end
            shadow_cnt[i] = '0;
          end
          w = lit * MM_PER_ELEMENT;
          if (w > 32'hFFFF) w = 32'hFFFF;
          // parallax correction, exact integer floor
          if (corr_cfg) begin
            if (it.diameter_mm >= CORR_BASE) w = 0;
            else w = w * (int'(CORR_BASE) - int'(it.diameter_mm)) / CORR_DEN;
          end
          // only a changed width is reported
          if (WIDTH_W'(w) != last_width_q) begin
            last_width_q       = WIDTH_W'(w);
            res.width_report   = 1'b1;
            res.width_mm       = (w > int'(WIDTH_OUT_MAX)) ? '1 : WIDTH_OUT_W'(w);
            res.width_ok       = (rises < 2);
          end
        end
      end
      presc_q = div_cfg;
    end else begin
      presc_q = presc_q - 1'b1;
    end
    res.mux_select = mux_q;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // tick driver: bursts with random gaps, sometimes holds off until drained
  // ---------------------------------------------------------------------------
  int   burst_left = 0;
  int   gap_left   = 0;
  int   n_holds    = 0;
  logic hold_drain = 1'b0;

  always @(posedge clk or negedge rst_n) begin : tick_driver
    logic     pres;
    in_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      pres = in_valid;
      nxt  = in_item;
      // accepted tick goes straight into the model
      if (in_valid && in_ready) begin
        width_q.push_back(tick_curtain(in_item));
        pres = 1'b0;
      end
      if (!pres) begin
        if (hold_drain) begin
          if (width_q.size() == 0) hold_drain = 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (tick_q.size() > 0) begin
          nxt  = tick_q.pop_front();
          pres = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // end of burst: new length, new gap, now and then wait for all results
            burst_left = $urandom_range(40, 1);
            gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            if (n_holds == 0 || $urandom_range(40, 0) == 0) begin
              hold_drain = 1'b1;
              n_holds++;
            end
          end
        end
      end
      // single update per edge keeps valid steady across back-to-back transfers
      in_valid <= pres;
      in_item  <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compares each transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  logic [7:0] stall_pat = 8'hFF;
  int         pat_left  = 0;

  always @(posedge clk or negedge rst_n) begin : result_monitor
    out_item_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (width_q.size() == 0) begin
          $error("result transfer with nothing expected: %p", out_item);
          errors++;
        end else begin
          exp_r = width_q.pop_front();
          if (out_item.mux_select !== exp_r.mux_select) begin
            $error("mux_select expected %0d actual %0d", exp_r.mux_select, out_item.mux_select);
            errors++;
          end
          if (out_item.width_report !== exp_r.width_report) begin
            $error("width_report expected %0d actual %0d",
                   exp_r.width_report, out_item.width_report);
            errors++;
          end
          if (out_item.width_mm !== exp_r.width_mm) begin
            $error("width_mm expected %0d actual %0d", exp_r.width_mm, out_item.width_mm);
            errors++;
          end
          if (out_item.width_ok !== exp_r.width_ok) begin
            $error("width_ok expected %0d actual %0d",
                   exp_r.width_ok, out_item.width_ok);
            errors++;
          end
        end
      end
      // stall pattern rotates every cycle and is redrawn per window
      if (pat_left == 0) begin
        pat_left = $urandom_range(96, 16);
        case ($urandom_range(3, 0))
          0: stall_pat = 8'hFF;
          1: stall_pat = 8'($urandom);
          2: stall_pat = 8'($urandom) | 8'($urandom);
          default: begin
            stall_pat = 8'h00;
            pat_left  = $urandom_range(40, 4);
          end
        endcase
      end else begin
        pat_left--;
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
      out_ready <= stall_pat[0];
    end
  end

  // watchdog on cycles with no transfer on any channel
  int quiet = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // block idle: no tick pending or in flight, every result seen
  task automatic wait_idle();
    while (tick_q.size() != 0 || in_valid || width_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write, unused data bits filled with noise
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    case (idx)
      REG_TICK_DIVISOR:      d[DIV_W-1:0]    = DIV_W'(val);
      REG_SWEEPS_LIMIT:      d[SWEEP_W-1:0]  = SWEEP_W'(val);
      REG_COUNT_THRESHOLD:   d[THRESH_W-1:0] = THRESH_W'(val);
      REG_CORRECTION_ENABLE: d[0]            = val[0];
      default: ;
    endcase
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic configure(input int div, input int sweeps, input int thr, input int corr);
    wait_idle();
    write_reg(REG_TICK_DIVISOR, div);
    write_reg(REG_SWEEPS_LIMIT, sweeps);
    write_reg(REG_COUNT_THRESHOLD, thr);
    write_reg(REG_CORRECTION_ENABLE, corr);
    if ($urandom_range(2, 0) == 0) write_reg(REG_UNUSED_FIRST, $urandom);
  endtask

  // ticks under a shadow profile redrawn every 16 to 200 ticks;
  // often one solid log, sometimes a split or ragged shadow, sometimes noise
  task automatic queue_ticks(input int n);
    int                pct [SENSOR_LINES];
    int                left, kind, lo, hi, k;
    logic [DIAM_W-1:0] diam;
    in_item_t          it;
    left = 0;
    diam = '0;
    repeat (n) begin
      if (left == 0) begin
        left = $urandom_range(200, 16);
        kind = $urandom_range(5, 0);
        lo   = $urandom_range(SENSOR_LINES - 1, 0);
        hi   = $urandom_range(SENSOR_LINES - 1, lo);
        for (k = 0; k < SENSOR_LINES; k++) begin
          case (kind)
            0, 1: pct[k] = (k >= lo && k <= hi) ? 100 : 0;
            2:    pct[k] = (k >= lo && k <= hi && k != (lo + hi) / 2) ? 100 : 0;
            3:    pct[k] = (k >= lo && k <= hi) ? 70 : 3;
            4:    pct[k] = (k == lo || k == hi) ? 50 : ((k > lo && k < hi) ? 100 : 0);
            default: pct[k] = $urandom_range(100, 0);
          endcase
        end
        case ($urandom_range(5, 0))
          0: diam = '0;
          1: diam = CORR_BASE - 1'b1;
          2: diam = CORR_BASE;
          3: diam = '1;
          default: diam = DIAM_W'($urandom_range(int'(CORR_BASE) - 1, 0));
        endcase
      end
      left--;
      for (k = 0; k < SENSOR_LINES; k++)
        it.sensor_bits[k] = ($urandom_range(99, 0) < pct[k]);
      it.diameter_mm = ($urandom_range(7, 0) == 0) ? DIAM_W'($urandom) : diam;
      tick_q.push_back(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int       budget, phase, n, div, sweeps, thr, corr, gap_line;
    in_item_t it;
    reset_curtain();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults straight out of reset, prescaler and mux stepping
    queue_ticks(40);

    // directed: full curtain, striped curtain, extremes of diameter
    configure(0, 1, 0, 1);
    repeat (8) tick_q.push_back(in_item_t'{sensor_bits: 10'h3FF, diameter_mm: '0});
    repeat (8) tick_q.push_back(in_item_t'{sensor_bits: 10'h155, diameter_mm: CORR_BASE});
    repeat (8) tick_q.push_back(in_item_t'{sensor_bits: 10'h2AA, diameter_mm: CORR_BASE - 1'b1});

    budget = RANDOM_TICKS;
    phase  = 0;
    while (budget > 0) begin
      if (phase == 3) begin
        // counter saturation: 128 sweeps of one sample each, threshold just below the cap
        configure(0, int'(SWEEP_W'('1)), int'(COUNT_MAX) - 1, 0);
        write_reg(REG_UNUSED_LAST, $urandom);
        gap_line = $urandom_range(8, 1);
        n = 1040 + $urandom_range(150, 0);
        repeat (n) begin
          it.sensor_bits = 10'h3FF;
          if (gap_line[0]) it.sensor_bits[gap_line] = 1'b0;
          it.diameter_mm = DIAM_W'($urandom);
          tick_q.push_back(it);
        end
        budget -= n;
      end
      // first phases pin the extremes, the rest are random
      if (phase == 0) begin
        div = 7; sweeps = 1; thr = int'(THRESH_W'('1)); corr = 1;
      end else if (phase == 1) begin
        div = 0; sweeps = 1; thr = 0; corr = 0;
      end else begin
        case ($urandom_range(3, 0))
          0:       div = int'(DIV_W'('1));
          1, 2:    div = 0;
          default: div = $urandom_range(int'(DIV_W'('1)), 0);
        endcase
        sweeps = ($urandom_range(4, 0) == 0) ? $urandom_range(12, 1) : $urandom_range(3, 1);
        case ($urandom_range(7, 0))
          0:       thr = 0;
          1:       thr = int'(THRESH_W'('1));
          default: thr = $urandom_range(sweeps + 1, 0);
        endcase
        corr = $urandom_range(1, 0);
      end
      configure(div, sweeps, thr, corr);
      n = 8 * (div + 1) * (sweeps + 1) * $urandom_range(3, 1) + $urandom_range(24, 0);
      if (n > 400) n = 400;
      if (n > budget) n = (budget > 0) ? budget : 0;
      queue_ticks(n);
      budget -= n;
      phase++;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mlcw_pkg.sv
rtl/mlcw_cell.sv
rtl/mlcw_scan.sv
rtl/mlcw_width.sv
rtl/multiplexed_light_curtain_width_core.sv
verif/multiplexed_light_curtain_width_core_tb.sv
